[src/ffea_pkg.sv]
// Shared types and constants of the first-fit extent allocator.
// Used by the controller, the datapath, the top level and the checker.
package ffea_pkg;

    localparam int MAX_ENTRIES_DEF = 128;
    localparam int ADDR_WIDTH_DEF  = 24;

    localparam int SIZE_W    = 24;
    localparam int IDX_IN_W  = 7;
    localparam int CNT_OUT_W = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0] BASE_RESET  = 24'd28008;
    localparam logic [SIZE_W-1:0] LIMIT_RESET = 24'd1048576;

    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef struct packed {
        logic    load;
        logic    walk;
        logic    shift;
        logic    commit;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_remove;
        logic full;
        logic bad_index;
        logic hit;
        logic scan_done;
        logic tail_fit;
    } t_dp_sts;

endpackage

[src/ffea_dp.sv]
// Datapath of the extent allocator: config registers, extent table memory,
// scan cursor, gap compare and result registers. Depends on ffea_pkg.
module ffea_dp #(
    parameter int MAX_ENTRIES = ffea_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_WIDTH  = ffea_pkg::ADDR_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ffea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_WIDTH-1:0]          i_cfg_data,
    input  logic                           i_op,
    input  logic [ffea_pkg::SIZE_W-1:0]    i_req_size,
    input  logic [ffea_pkg::IDX_IN_W-1:0]  i_entry_index,
    input  ffea_pkg::t_dp_cmd              i_cmd,
    output ffea_pkg::t_dp_sts              o_sts,
    output logic [ffea_pkg::STATUS_W-1:0]  o_status,
    output logic [ffea_pkg::SIZE_W-1:0]    o_placed_start,
    output logic [ffea_pkg::SIZE_W-1:0]    o_placed_end,
    output logic [ffea_pkg::CNT_OUT_W-1:0] o_entries_in_use
);
    import ffea_pkg::*;

    localparam int AW   = ADDR_WIDTH;
    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > IDX_IN_W) ? CW : IDX_IN_W;
    localparam int DW   = 2 * AW;

    localparam logic [AW+SIZE_W-1:0] BASE_EXT  = (AW + SIZE_W)'(BASE_RESET);
    localparam logic [AW+SIZE_W-1:0] LIMIT_EXT = (AW + SIZE_W)'(LIMIT_RESET);

    logic [DW-1:0]        r_mem [MAX_ENTRIES];
    logic [AW-1:0]        r_base;
    logic [AW-1:0]        r_limit;
    logic [CW-1:0]        r_count;
    logic                 r_op;
    logic [AW-1:0]        r_size;
    logic                 r_full;
    logic                 r_bad;
    logic [CW-1:0]        r_ptr;
    logic                 r_rd_vld;
    logic [IW-1:0]        r_rd_addr;
    logic [DW-1:0]        r_rd_data;
    logic [AW-1:0]        r_prev;
    logic [STATUS_W-1:0]  r_out_status;
    logic [SIZE_W-1:0]    r_out_start;
    logic [SIZE_W-1:0]    r_out_end;
    logic [CNT_OUT_W-1:0] r_out_cnt;

    logic [AW+SIZE_W-1:0]    size_ext;
    logic [CMPW-1:0]         idx_cmp;
    logic [CMPW-1:0]         cnt_cmp;
    logic [CMPW-1:0]         idx_next;
    logic                    more;
    logic                    rd_go;
    logic [AW-1:0]           rd_start;
    logic [AW-1:0]           rd_end;
    logic [AW-1:0]           gap;
    logic                    fit;
    logic [AW:0]             tail_sum;
    logic [AW-1:0]           place_end;
    logic                    ok_commit;
    logic                    append;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    logic [DW-1:0]           wr_data;
    logic [CW-1:0]           n_count;
    logic [AW+SIZE_W-1:0]    start_pad;
    logic [AW+SIZE_W-1:0]    end_pad;
    logic [CW+CNT_OUT_W-1:0] cnt_pad;

    assign size_ext  = {{AW{1'b0}}, i_req_size};
    assign idx_cmp   = CMPW'(i_entry_index);
    assign cnt_cmp   = CMPW'(r_count);
    assign idx_next  = idx_cmp + 1'b1;

    assign more      = (r_ptr < r_count);
    assign rd_go     = (i_cmd.walk || i_cmd.shift) && more;
    assign rd_start  = r_rd_data[DW-1:AW];
    assign rd_end    = r_rd_data[AW-1:0];
    assign gap       = rd_start - r_prev;
    assign fit       = (rd_start >= r_prev) && (gap >= r_size);
    assign tail_sum  = {1'b0, r_prev} + {1'b0, r_size};
    assign place_end = tail_sum[AW-1:0];

    assign ok_commit = i_cmd.commit && (i_cmd.status == ST_OK);
    assign append    = ok_commit && (r_op == OP_ALLOC);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rd_addr - 1'b1;
        wr_data = r_rd_data;
        if (i_cmd.shift && r_rd_vld) begin
            wr_en = 1'b1;
        end else if (append) begin
            wr_en   = 1'b1;
            wr_addr = r_count[IW-1:0];
            wr_data = {r_prev, place_end};
        end
    end

    always_comb begin
        n_count = r_count;
        if (ok_commit) begin
            if (r_op == OP_ALLOC) begin
                n_count = r_count + 1'b1;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    assign start_pad = {{SIZE_W{1'b0}}, r_prev};
    assign end_pad   = {{SIZE_W{1'b0}}, place_end};
    assign cnt_pad   = {{CNT_OUT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_go) begin
            r_rd_data <= r_mem[r_ptr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= BASE_EXT[AW-1:0];
            r_limit  <= LIMIT_EXT[AW-1:0];
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_BASE)) begin
                r_base <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_LIMIT)) begin
                r_limit <= i_cfg_data;
            end
            r_count  <= n_count;
            r_rd_vld <= i_cmd.load ? 1'b0 : rd_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_size <= size_ext[AW-1:0];
            r_full <= (r_count == CW'(MAX_ENTRIES));
            r_bad  <= (idx_cmp >= cnt_cmp);
            r_ptr  <= (i_op == OP_REMOVE) ? idx_next[CW-1:0] : '0;
            r_prev <= r_base;
        end else begin
            if (rd_go) begin
                r_ptr     <= r_ptr + 1'b1;
                r_rd_addr <= r_ptr[IW-1:0];
            end
            if (i_cmd.walk && r_rd_vld && !fit) begin
                r_prev <= rd_end;
            end
        end
        if (i_cmd.commit) begin
            r_out_status <= i_cmd.status;
            r_out_start  <= append ? start_pad[SIZE_W-1:0] : '0;
            r_out_end    <= append ? end_pad[SIZE_W-1:0] : '0;
            r_out_cnt    <= cnt_pad[CNT_OUT_W-1:0];
        end
    end

    assign o_sts.is_remove = (r_op == OP_REMOVE);
    assign o_sts.full      = r_full;
    assign o_sts.bad_index = r_bad;
    assign o_sts.hit       = r_rd_vld && fit;
    assign o_sts.scan_done = !more && !r_rd_vld;
    assign o_sts.tail_fit  = (tail_sum <= {1'b0, r_limit});

    assign o_status         = r_out_status;
    assign o_placed_start   = r_out_start;
    assign o_placed_end     = r_out_end;
    assign o_entries_in_use = r_out_cnt;

endmodule

[src/ffea_ctrl.sv]
// Controller of the extent allocator: request decode, scan sequencing and
// result handshake. Depends on ffea_pkg; drives ffea_dp by command struct.
module ffea_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  ffea_pkg::t_dp_sts i_sts,
    output ffea_pkg::t_dp_cmd o_cmd
);
    import ffea_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_SHIFT,
        S_FIN
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_status;
    t_status n_status;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    commit;

    assign commit = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = ST_OK;
                if (i_sts.is_remove) begin
                    if (i_sts.bad_index) begin
                        n_state  = S_FIN;
                        n_status = ST_BAD_INDEX;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (i_sts.full) begin
                    n_state  = S_FIN;
                    n_status = ST_FULL;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.hit) begin
                    n_state = S_FIN;
                end else if (i_sts.scan_done) begin
                    n_state  = S_FIN;
                    n_status = i_sts.tail_fit ? ST_OK : ST_NO_SPACE;
                end
            end
            S_SHIFT: begin
                if (i_sts.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.walk   = (r_state == S_WALK);
    assign o_cmd.shift  = (r_state == S_SHIFT);
    assign o_cmd.commit = commit;
    assign o_cmd.status = r_status;

endmodule

[src/first_fit_extent_allocator_top.sv]
// Top level of the first-fit extent allocator.
// Instantiates ffea_ctrl and ffea_dp; depends on ffea_pkg.
//
// Usage:
//   Request channel (i_valid / o_ready): i_op selects allocate or remove,
//   i_req_size is the extent size, i_entry_index the entry to remove.
//   Result channel (o_valid / i_ready): o_status, o_placed_start,
//   o_placed_end and o_entries_in_use, one result per request.
//   Config port: i_cfg_we writes i_cfg_data to region_base (index 0) or
//   region_limit (index 1); write only while no request is in flight.
// Timing:
//   One request at a time. An allocate scans the entries in use in table order,
//   stopping at the first gap that fits; the table scan reads one entry per
//   cycle from the extent memory. A remove moves every entry above the removed
//   index down, one entry per cycle. Full table and bad index results skip
//   the scan.
// Reset and stall:
//   Reset clears the entry count and loads the default region registers;
//   table contents are not cleared. The result stays in its output register
//   while i_ready is low; the next request is still accepted meanwhile.
module first_fit_extent_allocator_top #(
    parameter int MAX_ENTRIES = ffea_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_WIDTH  = ffea_pkg::ADDR_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ffea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_WIDTH-1:0]          i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_op,
    input  logic [ffea_pkg::SIZE_W-1:0]    i_req_size,
    input  logic [ffea_pkg::IDX_IN_W-1:0]  i_entry_index,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ffea_pkg::STATUS_W-1:0]  o_status,
    output logic [ffea_pkg::SIZE_W-1:0]    o_placed_start,
    output logic [ffea_pkg::SIZE_W-1:0]    o_placed_end,
    output logic [ffea_pkg::CNT_OUT_W-1:0] o_entries_in_use
);
    import ffea_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    ffea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ffea_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_op             (i_op),
        .i_req_size       (i_req_size),
        .i_entry_index    (i_entry_index),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_status         (o_status),
        .o_placed_start   (o_placed_start),
        .o_placed_end     (o_placed_end),
        .o_entries_in_use (o_entries_in_use)
    );

endmodule

[src/ffea_chk.sv]
// Port-level checker for the extent allocator and its bind to the top level.
// Depends on ffea_pkg.
module ffea_chk #(
    parameter int MAX_ENTRIES = ffea_pkg::MAX_ENTRIES_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [ffea_pkg::STATUS_W-1:0]  o_status,
    input logic [ffea_pkg::SIZE_W-1:0]    o_placed_start,
    input logic [ffea_pkg::SIZE_W-1:0]    o_placed_end,
    input logic [ffea_pkg::CNT_OUT_W-1:0] o_entries_in_use
);
    import ffea_pkg::*;

    localparam logic [CNT_OUT_W-1:0] FULL_CNT = CNT_OUT_W'(MAX_ENTRIES % 256);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |->
            (o_placed_start == '0) && (o_placed_end == '0))
        else $error("placement fields nonzero on failed request");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_entries_in_use == FULL_CNT))
        else $error("table full reported with wrong entry count");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            o_valid && $stable(o_status) && $stable(o_placed_start) &&
            $stable(o_placed_end) && $stable(o_entries_in_use))
        else $error("stalled result changed");

endmodule

bind first_fit_extent_allocator_top ffea_chk #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_ffea_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status         (o_status),
    .o_placed_start   (o_placed_start),
    .o_placed_end     (o_placed_end),
    .o_entries_in_use (o_entries_in_use)
);

[sim/tb_top.sv]
// Self-checking bench for first_fit_extent_allocator_top: a short table of directed allocate/
// remove requests (some with fixed expected results) and config writes, then random phases
// scored against an in-bench table model. Depends on ffea_pkg and the RTL of the allocator.
module tb_top;
    import ffea_pkg::*;

    localparam int DEPTH = MAX_ENTRIES_DEF;
    localparam int AW    = ADDR_WIDTH_DEF;
    localparam logic [AW-1:0] DEFAULT_BASE  = 24'd28008;
    localparam logic [AW-1:0] DEFAULT_LIMIT = 24'd1048576;
    localparam logic [AW-1:0] ADDR_MAX      = '1;
    localparam int RANDOM_ITEMS  = 1880;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = DEPTH + 16;
    localparam int MAX_PRINTED   = 60;

    typedef struct {
        t_status              status;
        logic [SIZE_W-1:0]    start_addr;
        logic [SIZE_W-1:0]    end_addr;
        logic [CNT_OUT_W-1:0] in_use;
    } result_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e            kind;
        logic                 op;
        logic [SIZE_W-1:0]    size;
        logic [IDX_IN_W-1:0]  idx;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [AW-1:0]        data;
        bit                   typed;
        result_t              want;
    } step_t;

    typedef enum int {PH_FILL, PH_CHURN, PH_DRAIN} phase_e;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_BASE;
    logic [AW-1:0]        i_cfg_data    = '0;
    logic                 i_valid       = 1'b0;
    logic                 o_ready;
    logic                 i_op          = OP_ALLOC;
    logic [SIZE_W-1:0]    i_req_size    = '0;
    logic [IDX_IN_W-1:0]  i_entry_index = '0;
    logic                 o_valid;
    logic                 i_ready       = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [SIZE_W-1:0]    o_placed_start;
    logic [SIZE_W-1:0]    o_placed_end;
    logic [CNT_OUT_W-1:0] o_entries_in_use;

    bit          quiet         = 1'b0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned results_seen  = 0;

    logic [AW-1:0] ext_start [DEPTH];
    logic [AW-1:0] ext_end   [DEPTH];
    int            ext_count;
    logic [AW-1:0] cur_base;
    logic [AW-1:0] cur_limit;
    result_t       pending_results [$];
    step_t         directed [$];
    result_t       no_result;

    first_fit_extent_allocator_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_req_size       (i_req_size),
        .i_entry_index    (i_entry_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_placed_start   (o_placed_start),
        .o_placed_end     (o_placed_end),
        .o_entries_in_use (o_entries_in_use)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= quiet || ($urandom_range(0, 99) >= 14);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("first_fit_extent_allocator_top verification failed");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("MISMATCH %s", msg);
        end
        error_count++;
    endtask

    function automatic result_t apply_request(input logic op, input logic [SIZE_W-1:0] size,
                                              input logic [IDX_IN_W-1:0] idx);
        result_t       r;
        logic [AW+1:0] prev;
        logic          found;
        r.status     = ST_OK;
        r.start_addr = '0;
        r.end_addr   = '0;
        found        = 1'b0;
        prev         = {2'b00, cur_base};
        if (op == OP_REMOVE) begin
            if (int'(idx) >= ext_count) begin
                r.status = ST_BAD_INDEX;
            end else begin
                for (int i = int'(idx); i + 1 < ext_count; i++) begin
                    ext_start[i] = ext_start[i + 1];
                    ext_end[i]   = ext_end[i + 1];
                end
                ext_count--;
            end
        end else if (ext_count >= DEPTH) begin
            r.status = ST_FULL;
        end else begin
            // first gap wide enough wins; an entry below the running end offers none
            for (int i = 0; i < ext_count && !found; i++) begin
                if ({2'b00, ext_start[i]} >= prev && {2'b00, ext_start[i]} - prev >= size) begin
                    found = 1'b1;
                end else begin
                    prev = {2'b00, ext_end[i]};
                end
            end
            if (!found && prev + size <= {2'b00, cur_limit}) begin
                found = 1'b1;
            end
            if (!found) begin
                r.status = ST_NO_SPACE;
            end else begin
                ext_start[ext_count] = prev[AW-1:0];
                ext_end[ext_count]   = prev[AW-1:0] + size;
                ext_count++;
                r.start_addr = prev[AW-1:0];
                r.end_addr   = prev[AW-1:0] + size;
            end
        end
        r.in_use = CNT_OUT_W'(ext_count);
        return r;
    endfunction

    always @(posedge i_clk) begin : score_results
        result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with no request pending",
                                        results_seen));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_placed_start !== want.start_addr ||
                    o_placed_end !== want.end_addr || o_entries_in_use !== want.in_use) begin
                    flag_mismatch($sformatf(
                        "result %0d got/want status %0d/%0d start %h/%h end %h/%h used %0d/%0d",
                        results_seen, o_status, want.status, o_placed_start, want.start_addr,
                        o_placed_end, want.end_addr, o_entries_in_use, want.in_use));
                end
            end
        end
    end

    task automatic send_request(input logic op, input logic [SIZE_W-1:0] size,
                                input logic [IDX_IN_W-1:0] idx, input bit typed,
                                input result_t want);
        result_t predicted;
        while (!quiet && $urandom_range(0, 99) < 14) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_op          = op;
        i_req_size    = size;
        i_entry_index = idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted = apply_request(op, size, idx);
        pending_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] sel, input logic [AW-1:0] value);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = sel;
        i_cfg_data  = value;
        @(posedge i_clk);
        if (sel == CFG_BASE) begin
            cur_base = value;
        end else begin
            cur_limit = value;
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic add_request(input logic op, input logic [SIZE_W-1:0] size,
                               input logic [IDX_IN_W-1:0] idx);
        step_t s;
        s.kind              = ROW_REQ;
        s.op                = op;
        s.size              = size;
        s.idx               = idx;
        s.reg_sel           = CFG_BASE;
        s.data              = '0;
        s.typed             = 1'b0;
        s.want.status       = ST_OK;
        s.want.start_addr   = '0;
        s.want.end_addr     = '0;
        s.want.in_use       = '0;
        directed.push_back(s);
    endtask

    task automatic add_checked(input logic op, input logic [SIZE_W-1:0] size,
                               input logic [IDX_IN_W-1:0] idx, input t_status status,
                               input logic [SIZE_W-1:0] start_addr,
                               input logic [SIZE_W-1:0] end_addr,
                               input logic [CNT_OUT_W-1:0] in_use);
        add_request(op, size, idx);
        directed[$].typed           = 1'b1;
        directed[$].want.status     = status;
        directed[$].want.start_addr = start_addr;
        directed[$].want.end_addr   = end_addr;
        directed[$].want.in_use     = in_use;
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] sel, input logic [AW-1:0] value);
        add_request(OP_ALLOC, '0, '0);
        directed[$].kind    = ROW_CFG;
        directed[$].reg_sel = sel;
        directed[$].data    = value;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return SIZE_W'($urandom);
            1, 2:    return SIZE_W'($urandom_range(0, 4095));
            default: return SIZE_W'($urandom_range(0, 64));
        endcase
    endfunction

    function automatic logic [IDX_IN_W-1:0] pick_index();
        if (ext_count > 0 && $urandom_range(0, 9) < 8) begin
            return IDX_IN_W'($urandom_range(0, ext_count - 1));
        end
        return IDX_IN_W'($urandom_range(0, 127));
    endfunction

    task automatic set_region(input phase_e kind);
        logic [AW-1:0] new_base;
        logic [AW-1:0] new_limit;
        if (kind == PH_FILL) begin
            new_base  = AW'($urandom_range(0, 50000));
            new_limit = ADDR_MAX;
        end else begin
            case ($urandom_range(0, 6))
                0: begin new_base = DEFAULT_BASE; new_limit = DEFAULT_LIMIT; end
                1: begin new_base = '0;           new_limit = ADDR_MAX;      end
                2: begin new_base = '0;           new_limit = '0;            end
                3: begin new_base = ADDR_MAX;     new_limit = ADDR_MAX;      end
                4: begin new_base = ADDR_MAX;     new_limit = '0;            end
                5: begin new_base = AW'($urandom); new_limit = AW'($urandom); end
                default: begin
                    new_base  = AW'($urandom_range(0, 1 << 20));
                    new_limit = AW'($urandom) | 24'hF00000;
                end
            endcase
        end
        write_register(CFG_BASE, new_base);
        write_register(CFG_LIMIT, new_limit);
    endtask

    initial begin
        phase_e              kind;
        int                  n;
        int                  sent;
        bit                  first;
        logic                op;
        logic [SIZE_W-1:0]   req_size_v;

        ext_count = 0;
        cur_base  = DEFAULT_BASE;
        cur_limit = DEFAULT_LIMIT;

        add_checked(OP_REMOVE, '0, 7'd0, ST_BAD_INDEX, '0, '0, 8'd0);
        add_checked(OP_REMOVE, '0, 7'd127, ST_BAD_INDEX, '0, '0, 8'd0);
        add_checked(OP_ALLOC, 24'd0, '0, ST_OK, DEFAULT_BASE, DEFAULT_BASE, 8'd1);
        add_checked(OP_ALLOC, 24'd100, '0, ST_OK, DEFAULT_BASE, DEFAULT_BASE + 24'd100, 8'd2);
        add_checked(OP_ALLOC, ADDR_MAX, '0, ST_NO_SPACE, '0, '0, 8'd2);
        add_checked(OP_ALLOC, DEFAULT_LIMIT - DEFAULT_BASE - 24'd100, '0, ST_OK,
                    DEFAULT_BASE + 24'd100, DEFAULT_LIMIT, 8'd3);
        add_checked(OP_ALLOC, 24'd1, '0, ST_NO_SPACE, '0, '0, 8'd3);
        add_checked(OP_REMOVE, '0, 7'd1, ST_OK, '0, '0, 8'd2);
        add_request(OP_ALLOC, 24'd100, 7'h7F);
        add_request(OP_ALLOC, 24'd0, '0);
        add_request(OP_REMOVE, '0, 7'd3);
        add_request(OP_REMOVE, '0, 7'd3);
        add_write(CFG_BASE, ADDR_MAX);
        add_request(OP_ALLOC, 24'd0, '0);
        add_request(OP_ALLOC, 24'd50, '0);
        add_write(CFG_LIMIT, '0);
        add_request(OP_ALLOC, 24'd7, '0);
        add_request(OP_REMOVE, '0, 7'd0);
        add_write(CFG_BASE, '0);
        add_write(CFG_LIMIT, ADDR_MAX);
        add_request(OP_ALLOC, 24'd28008, '0);
        add_request(OP_ALLOC, ADDR_MAX, '0);
        add_request(OP_ALLOC, 24'h800000, '0);
        add_request(OP_REMOVE, '0, 7'd64);
        add_request(OP_REMOVE, '0, 7'd1);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[r]) begin
            if (directed[r].kind == ROW_CFG) begin
                write_register(directed[r].reg_sel, directed[r].data);
            end else begin
                send_request(directed[r].op, directed[r].size, directed[r].idx,
                             directed[r].typed, directed[r].want);
            end
        end

        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            kind  = first ? PH_FILL : phase_e'($urandom_range(0, 2));
            first = 1'b0;
            set_region(kind);
            case (kind)
                PH_FILL:  n = 150;
                PH_CHURN: n = $urandom_range(80, 240);
                default:  n = ext_count + 20;
            endcase
            for (int k = 0; k < n && sent < RANDOM_ITEMS; k++) begin
                quiet = (sent >= 700 && sent < 1000);
                case (kind)
                    PH_FILL: begin
                        op         = ($urandom_range(0, 19) == 0) ? OP_REMOVE : OP_ALLOC;
                        req_size_v = SIZE_W'($urandom_range(0, 64));
                    end
                    PH_CHURN: begin
                        op         = $urandom_range(0, 1) ? OP_REMOVE : OP_ALLOC;
                        req_size_v = pick_size();
                    end
                    default: begin
                        op         = ($urandom_range(0, 9) == 0) ? OP_ALLOC : OP_REMOVE;
                        req_size_v = pick_size();
                    end
                endcase
                send_request(op, req_size_v, pick_index(), 1'b0, no_result);
                sent++;
            end
        end

        quiet   = 1'b0;
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("first_fit_extent_allocator_top verification clean");
        end else begin
            $display("first_fit_extent_allocator_top verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/ffea_pkg.sv
src/ffea_dp.sv
src/ffea_ctrl.sv
src/first_fit_extent_allocator_top.sv
src/ffea_chk.sv
sim/tb_top.sv
